FILE: hw/rtl/image_rotate_nearest_assert.svh
// ----------------------------------------------------------------------------
// image_rotate_nearest assertion macros
// Shared concurrent assertion forms for the rotator checkers.
// ----------------------------------------------------------------------------
`ifndef IMAGE_ROTATE_NEAREST_ASSERT_SVH
`define IMAGE_ROTATE_NEAREST_ASSERT_SVH

// Property checked only while out of reset.
`define IRN_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Property checked at every edge, reset included.
`define IRN_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/irn_pkg.sv
// ----------------------------------------------------------------------------
// irn_pkg
// Types, widths and codes shared by the nearest-neighbor rotator.
// ----------------------------------------------------------------------------
package irn_pkg;

    localparam int MAX_SIDE       = 256;
    localparam int STORE_DEPTH    = 65536;
    localparam int TRIG_FRAC_BITS = 14;

    localparam int ADDR_W  = $clog2(STORE_DEPTH);
    localparam int PIX_W   = 32;
    localparam int TRIG_W  = 16;
    localparam int DIM_W   = 9;
    localparam int POS_W   = 9;
    localparam int COORD_W = 8;                  // in-bounds coordinate, below MAX_SIDE
    localparam int DELTA_W = POS_W + 1;          // signed canvas offset
    localparam int PROD_W  = DELTA_W + TRIG_W;
    localparam int SUM_W   = PROD_W + 2;
    localparam int Q_W     = SUM_W - TRIG_FRAC_BITS;
    localparam int IDX_W   = 3;
    localparam int CFG_W   = 16;

    localparam logic [PIX_W-1:0] PIX_OUTSIDE = 32'hFFFF_FFFF;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_FETCH = 1'b1;

    localparam logic [IDX_W-1:0] REG_COS    = 3'd0;
    localparam logic [IDX_W-1:0] REG_SIN    = 3'd1;
    localparam logic [IDX_W-1:0] REG_WIDTH  = 3'd2;
    localparam logic [IDX_W-1:0] REG_HEIGHT = 3'd3;
    localparam logic [IDX_W-1:0] REG_SIDE   = 3'd4;

    typedef struct packed {
        logic signed [TRIG_W-1:0] cos_q14;
        logic signed [TRIG_W-1:0] sin_q14;
        logic [DIM_W-1:0]         width;     // clamped to MAX_SIDE
        logic [DIM_W-1:0]         height;    // clamped to MAX_SIDE
        logic [POS_W-2:0]         center;    // canvas_side / 2
    } t_cfg;

    typedef struct packed {
        logic              req_type;
        logic [ADDR_W-1:0] pixel_index;
        logic [PIX_W-1:0]  pixel_value;
        logic [POS_W-1:0]  out_x;
        logic [POS_W-1:0]  out_y;
    } t_req;

    typedef struct packed {
        logic               is_fetch;
        logic               hit;
        logic [COORD_W-1:0] rx;
        logic [COORD_W-1:0] ry;
        logic [ADDR_W-1:0]  pixel_index;
        logic [PIX_W-1:0]   pixel_value;
    } t_map;

endpackage

FILE: hw/rtl/irn_if.sv
// ----------------------------------------------------------------------------
// irn_if
// Request and result channels of the rotator, valid/ready handshake.
// ----------------------------------------------------------------------------
interface irn_req_if;
    logic                     valid;
    logic                     ready;
    logic                     req_type;
    logic [irn_pkg::ADDR_W-1:0] pixel_index;
    logic [irn_pkg::PIX_W-1:0]  pixel_value;
    logic [irn_pkg::POS_W-1:0]  out_x;
    logic [irn_pkg::POS_W-1:0]  out_y;

    modport source (output valid, req_type, pixel_index, pixel_value, out_x, out_y,
                    input ready);
    modport sink   (input valid, req_type, pixel_index, pixel_value, out_x, out_y,
                    output ready);
    modport mon    (input valid, ready, req_type, pixel_index, pixel_value, out_x, out_y);
endinterface

interface irn_res_if;
    logic                      valid;
    logic                      ready;
    logic [irn_pkg::PIX_W-1:0] pixel_out;
    logic                      inside_res;

    modport source (output valid, pixel_out, inside_res, input ready);
    modport sink   (input valid, pixel_out, inside_res, output ready);
    modport mon    (input valid, ready, pixel_out, inside_res);
endinterface

FILE: hw/rtl/irn_map.sv
// ----------------------------------------------------------------------------
// irn_map
// Inverse-rotates a canvas point: products stage, then sum, truncate, bounds.
// ----------------------------------------------------------------------------
module irn_map (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  irn_pkg::t_cfg i_cfg,
    input  logic          i_valid,
    input  irn_pkg::t_req i_item,
    output logic          o_ready,
    output logic          o_valid,
    output irn_pkg::t_map o_map,
    input  logic          i_ready
);

    localparam int F = irn_pkg::TRIG_FRAC_BITS;

    logic signed [irn_pkg::DELTA_W-1:0] dx, dy;
    logic signed [irn_pkg::PROD_W-1:0]  p_xc, p_ys, p_xs, p_yc;

    logic                               r_v1;
    logic signed [irn_pkg::PROD_W-1:0]  r_xc, r_ys, r_xs, r_yc;
    logic                               r_fetch1;
    logic [irn_pkg::ADDR_W-1:0]         r_index1;
    logic [irn_pkg::PIX_W-1:0]          r_value1;

    logic signed [irn_pkg::SUM_W-1:0]   sx, sy;
    logic signed [irn_pkg::Q_W-1:0]     qx, qy;
    logic signed [irn_pkg::Q_W-1:0]     rx, ry;
    logic                               in_x, in_y;

    logic                               r_v2;
    irn_pkg::t_map                      r_map;

    logic s1_en, s2_en;

    assign s2_en   = !r_v2 || i_ready;
    assign s1_en   = !r_v1 || s2_en;
    assign o_ready = s1_en;

    // Stage 1: offsets from the canvas center and the four products
    assign dx = $signed({1'b0, i_item.out_x}) - $signed({2'b00, i_cfg.center});
    assign dy = $signed({1'b0, i_item.out_y}) - $signed({2'b00, i_cfg.center});
    assign p_xc = dx * i_cfg.cos_q14;
    assign p_ys = dy * i_cfg.sin_q14;
    assign p_xs = dx * i_cfg.sin_q14;
    assign p_yc = dy * i_cfg.cos_q14;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (s1_en) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_en && i_valid) begin
            r_xc     <= p_xc;
            r_ys     <= p_ys;
            r_xs     <= p_xs;
            r_yc     <= p_yc;
            r_fetch1 <= (i_item.req_type == irn_pkg::REQ_FETCH);
            r_index1 <= i_item.pixel_index;
            r_value1 <= i_item.pixel_value;
        end
    end

    // Stage 2: sums, truncation toward zero, bounds
    assign sx = irn_pkg::SUM_W'(r_xc) - irn_pkg::SUM_W'(r_ys)
              + $signed({{(irn_pkg::SUM_W-irn_pkg::DIM_W+1-F){1'b0}},
                         i_cfg.width[irn_pkg::DIM_W-1:1], {F{1'b0}}});
    assign sy = irn_pkg::SUM_W'(r_xs) + irn_pkg::SUM_W'(r_yc)
              + $signed({{(irn_pkg::SUM_W-irn_pkg::DIM_W+1-F){1'b0}},
                         i_cfg.height[irn_pkg::DIM_W-1:1], {F{1'b0}}});

    assign qx = sx[irn_pkg::SUM_W-1:F];
    assign qy = sy[irn_pkg::SUM_W-1:F];

    // Round negative quotients up when any fraction bit is set
    assign rx = qx + irn_pkg::Q_W'(sx[irn_pkg::SUM_W-1] && (|sx[F-1:0]));
    assign ry = qy + irn_pkg::Q_W'(sy[irn_pkg::SUM_W-1] && (|sy[F-1:0]));

    assign in_x = !rx[irn_pkg::Q_W-1]
               && (rx[irn_pkg::Q_W-2:0] < (irn_pkg::Q_W-1)'(i_cfg.width));
    assign in_y = !ry[irn_pkg::Q_W-1]
               && (ry[irn_pkg::Q_W-2:0] < (irn_pkg::Q_W-1)'(i_cfg.height));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (s2_en) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_en && r_v1) begin
            r_map.is_fetch    <= r_fetch1;
            r_map.hit         <= in_x && in_y;
            r_map.rx          <= rx[irn_pkg::COORD_W-1:0];
            r_map.ry          <= ry[irn_pkg::COORD_W-1:0];
            r_map.pixel_index <= r_index1;
            r_map.pixel_value <= r_value1;
        end
    end

    assign o_valid = r_v2;
    assign o_map   = r_map;

endmodule

FILE: hw/rtl/irn_store.sv
// ----------------------------------------------------------------------------
// irn_store
// Pixel store: address forming, then one write or one registered read.
// ----------------------------------------------------------------------------
module irn_store (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  irn_pkg::t_cfg             i_cfg,
    input  logic                      i_valid,
    input  irn_pkg::t_map             i_map,
    output logic                      o_ready,
    output logic                      o_valid,
    output logic [irn_pkg::PIX_W-1:0] o_pixel,
    output logic                      o_inside,
    input  logic                      i_ready
);

    localparam int PROD_A_W = irn_pkg::COORD_W + irn_pkg::DIM_W;

    logic [irn_pkg::PIX_W-1:0] mem [irn_pkg::STORE_DEPTH];

    logic [PROD_A_W-1:0]        row_base;
    logic [PROD_A_W-1:0]        fetch_addr;

    logic                       r_v3;
    logic                       r_fetch3;
    logic                       r_inside3;
    logic [irn_pkg::ADDR_W-1:0] r_addr3;
    logic [irn_pkg::PIX_W-1:0]  r_value3;

    logic                       r_v4;
    logic                       r_inside4;
    logic [irn_pkg::PIX_W-1:0]  r_rd;

    logic s3_en, s4_en;

    assign s4_en   = !r_v4 || i_ready;
    assign s3_en   = !r_v3 || s4_en;
    assign o_ready = s3_en;

    assign row_base   = i_map.ry * i_cfg.width;
    assign fetch_addr = row_base + PROD_A_W'(i_map.rx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (s3_en) begin
            r_v3 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s3_en && i_valid) begin
            r_fetch3  <= i_map.is_fetch;
            r_inside3 <= i_map.hit;
            r_value3  <= i_map.pixel_value;
            r_addr3   <= i_map.is_fetch ? fetch_addr[irn_pkg::ADDR_W-1:0]
                                        : i_map.pixel_index;
        end
    end

    // Writes land here, in item order with the reads
    always_ff @(posedge i_clk) begin
        if (s4_en && r_v3) begin
            if (r_fetch3) begin
                r_rd <= mem[r_addr3];
            end else begin
                mem[r_addr3] <= r_value3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (s4_en) begin
            r_v4 <= r_v3 && r_fetch3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s4_en && r_v3) begin
            r_inside4 <= r_inside3;
        end
    end

    assign o_valid  = r_v4;
    assign o_inside = r_inside4;
    assign o_pixel  = r_inside4 ? r_rd : irn_pkg::PIX_OUTSIDE;

endmodule

FILE: hw/rtl/image_rotate_nearest.sv
// ----------------------------------------------------------------------------
// image_rotate_nearest
// Nearest-neighbor image rotator with an internal 64K x 32 pixel store.
// Throughput: one item per cycle while the result channel is not stalled, set by
// the four-stage pipeline and the single store port shared by writes and reads.
// An accepted fetch passes all four registered stages to its result; writes give none.
// Reset: synchronous, active low; clears pipeline valids and loads register
// defaults; the pixel store is not cleared.
// ----------------------------------------------------------------------------
module image_rotate_nearest (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [irn_pkg::IDX_W-1:0] i_cfg_idx,
    input  logic [irn_pkg::CFG_W-1:0] i_cfg_data,
    irn_req_if.sink                   i_req,
    irn_res_if.source                 o_res
);

    logic signed [irn_pkg::TRIG_W-1:0] r_cos, r_sin;
    logic [irn_pkg::DIM_W-1:0]         r_width, r_height, r_side;

    irn_pkg::t_cfg cfg;
    irn_pkg::t_req req;
    irn_pkg::t_map map;
    logic          map_valid, map_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cos    <= irn_pkg::TRIG_W'(1 << irn_pkg::TRIG_FRAC_BITS);
            r_sin    <= '0;
            r_width  <= irn_pkg::DIM_W'(irn_pkg::MAX_SIDE);
            r_height <= irn_pkg::DIM_W'(irn_pkg::MAX_SIDE);
            r_side   <= irn_pkg::DIM_W'(362);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                irn_pkg::REG_COS:    r_cos    <= i_cfg_data;
                irn_pkg::REG_SIN:    r_sin    <= i_cfg_data;
                irn_pkg::REG_WIDTH:  r_width  <= i_cfg_data[irn_pkg::DIM_W-1:0];
                irn_pkg::REG_HEIGHT: r_height <= i_cfg_data[irn_pkg::DIM_W-1:0];
                irn_pkg::REG_SIDE:   r_side   <= i_cfg_data[irn_pkg::DIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Clamp oversized dimensions
    always_comb begin
        cfg.cos_q14 = r_cos;
        cfg.sin_q14 = r_sin;
        cfg.width   = (r_width > irn_pkg::DIM_W'(irn_pkg::MAX_SIDE))
                    ? irn_pkg::DIM_W'(irn_pkg::MAX_SIDE) : r_width;
        cfg.height  = (r_height > irn_pkg::DIM_W'(irn_pkg::MAX_SIDE))
                    ? irn_pkg::DIM_W'(irn_pkg::MAX_SIDE) : r_height;
        cfg.center  = r_side[irn_pkg::DIM_W-1:1];
    end

    always_comb begin
        req.req_type    = i_req.req_type;
        req.pixel_index = i_req.pixel_index;
        req.pixel_value = i_req.pixel_value;
        req.out_x       = i_req.out_x;
        req.out_y       = i_req.out_y;
    end

    irn_map u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (i_req.valid),
        .i_item  (req),
        .o_ready (i_req.ready),
        .o_valid (map_valid),
        .o_map   (map),
        .i_ready (map_ready)
    );

    irn_store u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_valid  (map_valid),
        .i_map    (map),
        .o_ready  (map_ready),
        .o_valid  (o_res.valid),
        .o_pixel  (o_res.pixel_out),
        .o_inside (o_res.inside_res),
        .i_ready  (o_res.ready)
    );

endmodule

FILE: hw/rtl/irn_checker.sv
// ----------------------------------------------------------------------------
// irn_checker
// Port-level checks of the rotator request and result channels, bound to the top level.
// ----------------------------------------------------------------------------
`include "image_rotate_nearest_assert.svh"

module irn_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    irn_req_if.sink   i_req,
    irn_res_if.source o_res
);

    `IRN_ASSERT(a_res_hold, i_clk, i_rst_n,
                (o_res.valid && !o_res.ready) |=> o_res.valid,
                "result dropped while stalled")
    `IRN_ASSERT(a_res_stable, i_clk, i_rst_n,
                (o_res.valid && !o_res.ready)
                |=> ($stable(o_res.pixel_out) && $stable(o_res.inside_res)),
                "result changed while stalled")
    `IRN_ASSERT(a_outside_value, i_clk, i_rst_n,
                (o_res.valid && !o_res.inside_res)
                |-> (o_res.pixel_out == irn_pkg::PIX_OUTSIDE),
                "outside result not all ones")
    `IRN_ASSERT_ALWAYS(a_reset_clear, i_clk, !i_rst_n |=> !o_res.valid,
                       "result valid after reset")
    `IRN_ASSERT(a_write_silent, i_clk, i_rst_n,
                ($past(i_req.valid && i_req.ready
                       && (i_req.req_type == irn_pkg::REQ_WRITE), 4)
                 && $past(o_res.ready, 1) && $past(o_res.ready, 2)
                 && $past(o_res.ready, 3) && $past(o_res.ready, 4)
                 && $past(o_res.valid, 1)) |-> !o_res.valid,
                "write produced a result")

endmodule

bind image_rotate_nearest irn_checker u_irn_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_req   (i_req),
    .o_res   (o_res)
);

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for image_rotate_nearest. Fills the pixel store, fetches
// rotated canvas pixels under directed and random geometries, and compares
// every result with a fixed-point inverse-rotation predictor. It runs with the
// sender and the receiver idling at several rates.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     CLK_PERIOD   = 12;
    localparam int     RESET_CYCLES = 11;
    localparam int     PIPE_LATENCY = 4;
    localparam int     QUIET_LIMIT  = 2000;   // far beyond any 78% idle streak
    localparam int     SET_ITEMS    = 85;
    localparam longint Q_ONE        = longint'(1) << irn_pkg::TRIG_FRAC_BITS;

    typedef struct packed {
        logic [irn_pkg::PIX_W-1:0] pixel;
        logic                      in_image;
    } t_rotated_pixel;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic [irn_pkg::IDX_W-1:0] i_cfg_idx;
    logic [irn_pkg::CFG_W-1:0] i_cfg_data;

    irn_req_if req_ch ();
    irn_res_if res_ch ();

    image_rotate_nearest DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_ch.sink),
        .o_res      (res_ch.source)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Shadow copy of the geometry registers, reset values
    logic signed [irn_pkg::TRIG_W-1:0] cfg_cos    = 16384;
    logic signed [irn_pkg::TRIG_W-1:0] cfg_sin    = 0;
    logic [irn_pkg::DIM_W-1:0]         cfg_width  = 256;
    logic [irn_pkg::DIM_W-1:0]         cfg_height = 256;
    logic [irn_pkg::DIM_W-1:0]         cfg_side   = 362;

    logic [irn_pkg::PIX_W-1:0] source_pixels [int];
    t_rotated_pixel            pending_pixels [$];
    int                        mismatch_count = 0;
    int                        src_idle_pct   = 0;
    int                        snk_stall_pct  = 0;

    // Inverse-rotate a canvas point into the source image
    function automatic void map_to_source(input logic [irn_pkg::POS_W-1:0] x, y,
                                          output logic hit,
                                          output logic [irn_pkg::ADDR_W-1:0] addr);
        longint center, dx, dy, cs, sn, w, h, sx, sy, rx, ry;
        center = longint'(cfg_side) / 2;
        dx     = longint'(x) - center;
        dy     = longint'(y) - center;
        cs     = longint'(cfg_cos);
        sn     = longint'(cfg_sin);
        w      = (cfg_width > irn_pkg::MAX_SIDE) ? longint'(irn_pkg::MAX_SIDE)
                                                 : longint'(cfg_width);
        h      = (cfg_height > irn_pkg::MAX_SIDE) ? longint'(irn_pkg::MAX_SIDE)
                                                  : longint'(cfg_height);
        sx     = dx * cs - dy * sn + (w / 2) * Q_ONE;
        sy     = dx * sn + dy * cs + (h / 2) * Q_ONE;
        // signed division truncates toward zero
        rx     = sx / Q_ONE;
        ry     = sy / Q_ONE;
        hit    = (rx >= 0) && (rx < w) && (ry >= 0) && (ry < h);
        addr   = irn_pkg::ADDR_W'(ry * w + rx);
    endfunction

    task automatic send_item(input irn_pkg::t_req item);
        t_rotated_pixel             want;
        logic                       hit;
        logic [irn_pkg::ADDR_W-1:0] addr;
        while ($urandom_range(99) < src_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.req_type    <= item.req_type;
        req_ch.pixel_index <= item.pixel_index;
        req_ch.pixel_value <= item.pixel_value;
        req_ch.out_x       <= item.out_x;
        req_ch.out_y       <= item.out_y;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        if (item.req_type == irn_pkg::REQ_WRITE) begin
            source_pixels[int'(item.pixel_index)] = item.pixel_value;
        end else begin
            map_to_source(item.out_x, item.out_y, hit, addr);
            want.in_image = hit;
            want.pixel    = hit ? source_pixels[int'(addr)] : irn_pkg::PIX_OUTSIDE;
            pending_pixels.push_back(want);
        end
        @(negedge i_clk);
    endtask

    task automatic put_pixel(input logic [irn_pkg::ADDR_W-1:0] index,
                             input logic [irn_pkg::PIX_W-1:0] value);
        irn_pkg::t_req item;
        item.req_type    = irn_pkg::REQ_WRITE;
        item.pixel_index = index;
        item.pixel_value = value;
        item.out_x       = irn_pkg::POS_W'($urandom());
        item.out_y       = irn_pkg::POS_W'($urandom());
        send_item(item);
    endtask

    // Store the mapped source pixel first when it was never written
    task automatic fetch_pixel(input logic [irn_pkg::POS_W-1:0] x, y);
        irn_pkg::t_req              item;
        logic                       hit;
        logic [irn_pkg::ADDR_W-1:0] addr;
        map_to_source(x, y, hit, addr);
        if (hit && !source_pixels.exists(int'(addr)))
            put_pixel(addr, $urandom());
        item.req_type    = irn_pkg::REQ_FETCH;
        item.pixel_index = irn_pkg::ADDR_W'($urandom());
        item.pixel_value = $urandom();
        item.out_x       = x;
        item.out_y       = y;
        send_item(item);
    endtask

    task automatic wait_for_results();
        req_ch.valid <= 1'b0;
        while (pending_pixels.size() != 0) @(negedge i_clk);
        // writes leave nothing to wait for; let them clear the pipeline
        repeat (2 * PIPE_LATENCY) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [irn_pkg::IDX_W-1:0] idx,
                             input logic [irn_pkg::CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
    endtask

    task automatic apply_geometry(input logic signed [irn_pkg::TRIG_W-1:0] cos_v, sin_v,
                                  input logic [irn_pkg::DIM_W-1:0] w, h, side);
        wait_for_results();
        write_reg(irn_pkg::REG_COS, cos_v);
        write_reg(irn_pkg::REG_SIN, sin_v);
        write_reg(irn_pkg::REG_WIDTH, irn_pkg::CFG_W'(w));
        write_reg(irn_pkg::REG_HEIGHT, irn_pkg::CFG_W'(h));
        write_reg(irn_pkg::REG_SIDE, irn_pkg::CFG_W'(side));
        i_cfg_we   <= 1'b0;
        cfg_cos    = cos_v;
        cfg_sin    = sin_v;
        cfg_width  = w;
        cfg_height = h;
        cfg_side   = side;
    endtask

    // Reset geometry: identity on a 256x256 image, canvas 362
    task automatic test_identity_corners();
        put_pixel(16'h0000, 32'h0000_0000);
        put_pixel(16'hFFFF, 32'hFFFF_FFFF);
        fetch_pixel(53, 53);
        fetch_pixel(308, 308);
        fetch_pixel(181, 181);
        fetch_pixel(52, 53);
        fetch_pixel(309, 308);
        fetch_pixel(0, 0);
        fetch_pixel(511, 511);
    endtask

    task automatic test_special_geometry();
        // half scale: -0.5 truncates to 0 and stays inside
        apply_geometry(8192, 0, 2, 2, 6);
        put_pixel(16'd2, 32'hA5A5_A5A5);
        fetch_pixel(0, 3);
        fetch_pixel(0, 0);
        // zero width, then zero height: all outside
        apply_geometry(16384, 0, 0, 5, 10);
        fetch_pixel(5, 5);
        apply_geometry(16384, 0, 5, 0, 10);
        fetch_pixel(5, 5);
        // oversized dimensions clamp to the maximum side
        apply_geometry(16384, 0, 511, 300, 362);
        fetch_pixel(181, 181);
        fetch_pixel(308, 308);
        fetch_pixel(309, 308);
        // zero canvas: center at the origin
        apply_geometry(16384, 0, 256, 256, 0);
        fetch_pixel(127, 127);
        fetch_pixel(128, 0);
        // trig values past unity
        apply_geometry(16'sh8000, 16'sh7FFF, 256, 256, 362);
        fetch_pixel(182, 181);
        fetch_pixel(181, 182);
        // quarter turn with negative sine, widest canvas
        apply_geometry(0, -16384, 256, 256, 511);
        fetch_pixel(300, 200);
        fetch_pixel(511, 511);
    endtask

    task automatic test_random_rotations(input int idle_pct, stall_pct);
        int unsigned                       w, h, side, area;
        real                               angle;
        logic signed [irn_pkg::TRIG_W-1:0] cs, sn;
        src_idle_pct  = idle_pct;
        snk_stall_pct = stall_pct;
        repeat (3) begin
            if ($urandom_range(3) == 0) begin
                cs   = irn_pkg::TRIG_W'($urandom());
                sn   = irn_pkg::TRIG_W'($urandom());
                w    = $urandom_range(511);
                h    = $urandom_range(511);
                side = $urandom_range(511);
            end else begin
                angle = $urandom_range(359) * 3.14159265358979 / 180.0;
                cs    = irn_pkg::TRIG_W'($rtoi($cos(angle) * 16384.0));
                sn    = irn_pkg::TRIG_W'($rtoi($sin(angle) * 16384.0));
                w     = ($urandom_range(9) < 7) ? $urandom_range(32, 1)
                                                : $urandom_range(256, 1);
                h     = ($urandom_range(9) < 7) ? $urandom_range(32, 1)
                                                : $urandom_range(256, 1);
                side  = $rtoi($sqrt(real'(w * w + h * h)));
            end
            apply_geometry(cs, sn, irn_pkg::DIM_W'(w), irn_pkg::DIM_W'(h),
                           irn_pkg::DIM_W'(side));
            area = ((w > irn_pkg::MAX_SIDE) ? irn_pkg::MAX_SIDE : w)
                 * ((h > irn_pkg::MAX_SIDE) ? irn_pkg::MAX_SIDE : h);
            for (int n = 0; n < SET_ITEMS; n++) begin
                // hold the sender until the pipeline has drained
                if (n == SET_ITEMS / 2)
                    wait_for_results();
                if ($urandom_range(99) < 30) begin
                    if (area > 0 && $urandom_range(1) == 1)
                        put_pixel(irn_pkg::ADDR_W'($urandom_range(area - 1)), $urandom());
                    else
                        put_pixel(irn_pkg::ADDR_W'($urandom()), $urandom());
                end else if (side > 0 && $urandom_range(99) < 85) begin
                    fetch_pixel(irn_pkg::POS_W'($urandom_range(side - 1)),
                                irn_pkg::POS_W'($urandom_range(side - 1)));
                end else begin
                    fetch_pixel(irn_pkg::POS_W'($urandom_range(511)),
                                irn_pkg::POS_W'($urandom_range(511)));
                end
            end
        end
    endtask

    always @(negedge i_clk) begin
        res_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    always @(posedge i_clk) begin : check_results
        t_rotated_pixel want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_pixels.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result: expected none, actual %08h %0b",
                         $time, res_ch.pixel_out, res_ch.inside_res);
            end else begin
                want = pending_pixels.pop_front();
                if (res_ch.pixel_out !== want.pixel) begin
                    mismatch_count++;
                    $display("%0t: pixel_out expected %08h actual %08h",
                             $time, want.pixel, res_ch.pixel_out);
                end
                if (res_ch.inside_res !== want.in_image) begin
                    mismatch_count++;
                    $display("%0t: inside_res expected %0b actual %0b",
                             $time, want.in_image, res_ch.inside_res);
                end
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        i_rst_n            <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_idx          <= irn_pkg::REG_COS;
        i_cfg_data         <= '0;
        req_ch.valid       <= 1'b0;
        req_ch.req_type    <= irn_pkg::REQ_WRITE;
        req_ch.pixel_index <= '0;
        req_ch.pixel_value <= '0;
        req_ch.out_x       <= '0;
        req_ch.out_y       <= '0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_identity_corners();
        test_special_geometry();
        test_random_rotations(0, 0);
        test_random_rotations(78, 0);
        test_random_rotations(0, 78);
        test_random_rotations(25, 25);
        wait_for_results();

        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

FILE: image_rotate_nearest.f
+incdir+hw/rtl
hw/rtl/irn_pkg.sv
hw/rtl/irn_if.sv
hw/rtl/irn_map.sv
hw/rtl/irn_store.sv
hw/rtl/image_rotate_nearest.sv
hw/rtl/irn_checker.sv
bench/tb_top.sv
